// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the allocator RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that also holds through reset.
`define ASSERT_CLK_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/nfba_pkg.sv =====
// ---------------------------------------------------------------------------
// nfba_pkg
// Widths, codes and types of the next-fit bitmap extent allocator.
// ---------------------------------------------------------------------------
package nfba_pkg;

  localparam int MAX_EXTENTS = 1024;
  localparam int WORD_W      = 32;
  localparam int WORDS       = MAX_EXTENTS / WORD_W;
  localparam int ID_W        = $clog2(MAX_EXTENTS);
  localparam int CNT_W       = $clog2(MAX_EXTENTS + 1);
  localparam int BIT_W       = $clog2(WORD_W);
  localparam int ROW_W       = ID_W - BIT_W;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BAD_FREE = 2'd2
  } status_t;

endpackage

// ===== rtl/core/nfba_ifs.sv =====
// ---------------------------------------------------------------------------
// nfba channels
// Valid/ready channels for requests, responses and the extent-count write.
// ---------------------------------------------------------------------------
interface nfba_req_if;
  logic                     valid;
  logic                     ready;
  nfba_pkg::cmd_t           cmd;
  logic [nfba_pkg::ID_W-1:0] extent_id;

  modport source (output valid, output cmd, output extent_id, input ready);
  modport sink   (input valid, input cmd, input extent_id, output ready);
endinterface

interface nfba_rsp_if;
  logic                       valid;
  logic                       ready;
  nfba_pkg::status_t          status;
  logic [nfba_pkg::ID_W-1:0]  granted_id;
  logic [nfba_pkg::CNT_W-1:0] used_count;
  logic                       space_empty;

  modport source (output valid, output status, output granted_id, output used_count,
                  output space_empty, input ready);
  modport sink   (input valid, input status, input granted_id, input used_count,
                  input space_empty, output ready);
endinterface

interface nfba_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [nfba_pkg::CNT_W-1:0] num_extents;

  modport source (output valid, output num_extents, input ready);
  modport sink   (input valid, input num_extents, output ready);
endinterface

// ===== rtl/core/next_fit_bitmap_extent_allocator.sv =====
// ---------------------------------------------------------------------------
// next_fit_bitmap_extent_allocator
// Next-fit allocator over a bitmap of extents held in a word-wide RAM.
// ---------------------------------------------------------------------------
// Usage:
//   req  : one item per request, cmd selects allocate or free of extent_id.
//   rsp  : one item per request with status, granted_id, used_count and
//          space_empty (used_count after the request).
//   cfg  : writes the active extent count; always ready, write only when idle.
// Bitmap reads: an item reads 32-bit bitmap words through the single read port
//   of the bitmap RAM, one word per cycle. A free reads one word. An allocate
//   reads from the word of the search start up to the last active word, then
//   wraps once from word zero, stopping at the first word with a free extent.
// One item is in work at a time; req.ready is high while the sequencer idles.
// The response sits in an output register; the next item is accepted while
//   it waits, and a finished item holds until that register is free.
// Reset: the bitmap reads as all free at once through one flag per word,
//   count and search start clear, the extent count returns to 1024 and the
//   block takes an item in the first cycle after reset.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module next_fit_bitmap_extent_allocator (
  input  logic       clk,
  input  logic       rst,
  nfba_req_if.sink   req,
  nfba_rsp_if.source rsp,
  nfba_cfg_if.sink   cfg
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_DONE
  } state_t;

  state_t state;

  logic [nfba_pkg::CNT_W-1:0]  num_extents;
  logic [nfba_pkg::ID_W-1:0]   search_start;
  logic [nfba_pkg::CNT_W-1:0]  allocated_total;
  logic [nfba_pkg::WORDS-1:0]  row_valid;

  nfba_pkg::cmd_t              cmd_q;
  logic [nfba_pkg::ID_W-1:0]   eid_q;
  logic [nfba_pkg::ROW_W-1:0]  cur_row;
  logic                        phase;

  nfba_pkg::status_t           res_status;
  logic [nfba_pkg::ID_W-1:0]   res_granted;
  logic [nfba_pkg::CNT_W-1:0]  res_count;

  logic                        rsp_valid;
  nfba_pkg::status_t           rsp_status;
  logic [nfba_pkg::ID_W-1:0]   rsp_granted;
  logic [nfba_pkg::CNT_W-1:0]  rsp_count;

  logic                        rd_en;
  logic [nfba_pkg::ROW_W-1:0]  rd_addr;
  logic [nfba_pkg::WORD_W-1:0] rd_data;
  logic                        wr_en;
  logic [nfba_pkg::WORD_W-1:0] wr_data;

  logic [nfba_pkg::CNT_W-1:0]  n_act;
  logic [nfba_pkg::CNT_W-1:0]  n_m1;
  logic                        n_zero;
  logic [nfba_pkg::ROW_W-1:0]  last_row;
  logic [nfba_pkg::CNT_W-1:0]  lo_bound;
  logic [nfba_pkg::WORD_W-1:0] word;
  logic [nfba_pkg::WORD_W-1:0] cand;
  logic                        found;
  logic [nfba_pkg::BIT_W-1:0]  first;
  logic                        at_end;
  logic                        grant;
  logic                        free_ok;
  logic                        scan_more;
  logic [nfba_pkg::ROW_W-1:0]  next_row;
  logic [nfba_pkg::CNT_W-1:0]  total_next;
  logic                        accept;
  logic                        out_free;

  nfba_ram #(
    .WIDTH (nfba_pkg::WORD_W),
    .DEPTH (nfba_pkg::WORDS)
  ) u_map (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cur_row),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign accept    = req.valid && req.ready;
  assign out_free  = !rsp_valid || rsp.ready;

  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_status;
  assign rsp.granted_id  = rsp_granted;
  assign rsp.used_count  = rsp_count;
  assign rsp.space_empty = (rsp_count == '0);

  // Clamp the configured count to the bitmap size.
  assign n_act    = (num_extents > nfba_pkg::CNT_W'(nfba_pkg::MAX_EXTENTS)) ?
                    nfba_pkg::CNT_W'(nfba_pkg::MAX_EXTENTS) : num_extents;
  assign n_zero   = (n_act == '0);
  assign n_m1     = n_act - nfba_pkg::CNT_W'(1);
  assign last_row = n_m1[nfba_pkg::ID_W-1:nfba_pkg::BIT_W];
  assign lo_bound = phase ? '0 : {1'b0, search_start};

  // Rows never written since reset read as all free.
  assign word = row_valid[cur_row] ? rd_data : '0;

  always_comb begin
    logic [nfba_pkg::CNT_W-1:0] idx;
    cand  = '0;
    first = '0;
    for (int i = 0; i < nfba_pkg::WORD_W; i++) begin
      idx     = {1'b0, cur_row, nfba_pkg::BIT_W'(i)};
      cand[i] = !word[i] && (idx >= lo_bound) && (idx < n_act);
    end
    for (int i = nfba_pkg::WORD_W - 1; i >= 0; i--) begin
      if (cand[i]) begin
        first = nfba_pkg::BIT_W'(i);
      end
    end
  end

  assign found   = |cand;
  assign at_end  = (cur_row >= last_row);
  assign grant   = (state == S_EVAL) && (cmd_q == nfba_pkg::CMD_ALLOC) && !n_zero && found;
  assign free_ok = (state == S_EVAL) && (cmd_q == nfba_pkg::CMD_FREE) &&
                   ({1'b0, eid_q} < n_act) && word[eid_q[nfba_pkg::BIT_W-1:0]];
  assign scan_more = (state == S_EVAL) && (cmd_q == nfba_pkg::CMD_ALLOC) && !n_zero &&
                     !found && !(at_end && phase);
  // Wrap to word zero once the first pass reaches the last active word.
  assign next_row  = at_end ? '0 : cur_row + nfba_pkg::ROW_W'(1);

  always_comb begin
    total_next = allocated_total;
    if (grant) begin
      total_next = allocated_total + nfba_pkg::CNT_W'(1);
    end else if (free_ok && (allocated_total != '0)) begin
      total_next = allocated_total - nfba_pkg::CNT_W'(1);
    end
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = next_row;
    if (accept) begin
      rd_en   = 1'b1;
      rd_addr = (req.cmd == nfba_pkg::CMD_FREE) ?
                req.extent_id[nfba_pkg::ID_W-1:nfba_pkg::BIT_W] :
                search_start[nfba_pkg::ID_W-1:nfba_pkg::BIT_W];
    end else if (scan_more) begin
      rd_en = 1'b1;
    end
  end

  assign wr_en   = grant || free_ok;
  assign wr_data = grant ? (word | (nfba_pkg::WORD_W'(1) << first)) :
                   (word & ~(nfba_pkg::WORD_W'(1) << eid_q[nfba_pkg::BIT_W-1:0]));

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      num_extents     <= nfba_pkg::CNT_W'(nfba_pkg::MAX_EXTENTS);
      search_start    <= '0;
      allocated_total <= '0;
      row_valid       <= '0;
      phase           <= 1'b0;
      rsp_valid       <= 1'b0;
    end else begin
      if (cfg.valid) begin
        num_extents <= cfg.num_extents;
      end
      if (rsp_valid && rsp.ready && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cmd_q   <= req.cmd;
            eid_q   <= req.extent_id;
            cur_row <= rd_addr;
            phase   <= 1'b0;
            state   <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (scan_more) begin
            cur_row <= next_row;
            phase   <= phase | at_end;
          end else begin
            if (wr_en) begin
              row_valid[cur_row] <= 1'b1;
            end
            if (grant) begin
              search_start <= {cur_row, first};
            end
            allocated_total <= total_next;
            res_count       <= total_next;
            res_granted     <= grant ? {cur_row, first} : '0;
            if (cmd_q == nfba_pkg::CMD_ALLOC) begin
              res_status <= grant ? nfba_pkg::ST_OK : nfba_pkg::ST_FULL;
            end else begin
              res_status <= free_ok ? nfba_pkg::ST_OK : nfba_pkg::ST_BAD_FREE;
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // Hold the result until the output register frees up.
          if (out_free) begin
            rsp_valid   <= 1'b1;
            rsp_status  <= res_status;
            rsp_granted <= res_granted;
            rsp_count   <= res_count;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_CLK(a_grant_in_range, clk, rst, grant |-> ({1'b0, cur_row, first} < n_act), "granted extent beyond active count")
  `ASSERT_CLK(a_grant_counts, clk, rst, grant |=> (allocated_total == $past(allocated_total) + nfba_pkg::CNT_W'(1)), "grant did not bump the count")
  `ASSERT_CLK(a_no_rw_clash, clk, rst, !(wr_en && rd_en && (rd_addr == cur_row)), "bitmap read and write to one word in one cycle")
  `ASSERT_CLK(a_count_bound, clk, rst, allocated_total <= nfba_pkg::CNT_W'(nfba_pkg::MAX_EXTENTS), "used count above bitmap size")

endmodule

// ===== rtl/core/nfba_ram.sv =====
// ---------------------------------------------------------------------------
// nfba_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module nfba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== tb/next_fit_bitmap_extent_allocator_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// next_fit_bitmap_extent_allocator_tb
// Drives allocate and free requests at the allocator under several extent
// counts. A scripted opening covers reset, wrap-around, full, bad frees and a
// count shrunk below the used extents; random traffic follows. Every response
// is checked against a typed row's script or else a bitmap predictor in the bench.
// ---------------------------------------------------------------------------
module next_fit_bitmap_extent_allocator_tb;

  localparam int STALL_CYCLES = 300;
  localparam int QUIET_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 70;
  localparam int PHASES       = 12;

  typedef struct packed {
    nfba_pkg::status_t            status;
    logic [nfba_pkg::ID_W-1:0]    granted;
    logic [nfba_pkg::CNT_W-1:0]   count;
    logic                         empty;
  } outcome_t;

  typedef enum logic {
    ROW_REQ = 1'b0,
    ROW_CFG = 1'b1
  } row_kind_t;

  typedef struct packed {
    row_kind_t      kind;
    nfba_pkg::cmd_t cmd;
    int             arg;
    bit             typed;
    outcome_t       want;
  } row_t;

  logic clk = 1'b0;
  logic rst;

  nfba_req_if req_ch ();
  nfba_rsp_if rsp_ch ();
  nfba_cfg_if cfg_ch ();

  next_fit_bitmap_extent_allocator u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state
  bit                         in_use [nfba_pkg::MAX_EXTENTS];
  logic [nfba_pkg::ID_W-1:0]  search_pos   = '0;
  logic [nfba_pkg::CNT_W-1:0] used_total   = '0;
  logic [nfba_pkg::CNT_W-1:0] extent_limit = nfba_pkg::CNT_W'(1024);

  outcome_t outcome_q [$];
  int       fail_count   = 0;
  int       src_idle_pct = 11;
  int       rcv_idle_pct = 60;
  int       hold_asks    = 0;
  bit       req_up       = 1'b0;

  // Opening script: arg is the extent id for a request, the count for a write
  row_t opening_rows [25] = '{
    '{ROW_REQ, nfba_pkg::CMD_ALLOC, 1023, 1'b1, '{nfba_pkg::ST_OK,       0, 1, 0}},
    '{ROW_REQ, nfba_pkg::CMD_ALLOC, 0,    1'b0, '{nfba_pkg::ST_OK,       0, 0, 0}},
    '{ROW_REQ, nfba_pkg::CMD_FREE,  0,    1'b0, '{nfba_pkg::ST_OK,       0, 0, 0}},
    '{ROW_REQ, nfba_pkg::CMD_FREE,  0,    1'b1, '{nfba_pkg::ST_BAD_FREE, 0, 1, 0}},
    '{ROW_REQ, nfba_pkg::CMD_FREE,  1023, 1'b1, '{nfba_pkg::ST_BAD_FREE, 0, 1, 0}},
    '{ROW_REQ, nfba_pkg::CMD_FREE,  1,    1'b1, '{nfba_pkg::ST_OK,       0, 0, 1}},
    '{ROW_REQ, nfba_pkg::CMD_ALLOC, 682,  1'b0, '{nfba_pkg::ST_OK,       0, 0, 0}},
    '{ROW_CFG, nfba_pkg::CMD_ALLOC, 0,    1'b0, '{nfba_pkg::ST_OK,       0, 0, 0}},
    '{ROW_REQ, nfba_pkg::CMD_ALLOC, 341,  1'b1, '{nfba_pkg::ST_FULL,     0, 1, 0}},
    '{ROW_REQ, nfba_pkg::CMD_FREE,  1,    1'b1, '{nfba_pkg::ST_BAD_FREE, 0, 1, 0}},
    '{ROW_CFG, nfba_pkg::CMD_ALLOC, 2,    1'b0, '{nfba_pkg::ST_OK,       0, 0, 0}},
    '{ROW_REQ, nfba_pkg::CMD_ALLOC, 0,    1'b0, '{nfba_pkg::ST_OK,       0, 0, 0}},
    '{ROW_REQ, nfba_pkg::CMD_ALLOC, 0,    1'b1, '{nfba_pkg::ST_FULL,     0, 2, 0}},
    '{ROW_REQ, nfba_pkg::CMD_FREE,  1,    1'b0, '{nfba_pkg::ST_OK,       0, 0, 0}},
    '{ROW_REQ, nfba_pkg::CMD_ALLOC, 1023, 1'b0, '{nfba_pkg::ST_OK,       0, 0, 0}},
    '{ROW_CFG, nfba_pkg::CMD_ALLOC, 2047, 1'b0, '{nfba_pkg::ST_OK,       0, 0, 0}},
    '{ROW_REQ, nfba_pkg::CMD_ALLOC, 0,    1'b0, '{nfba_pkg::ST_OK,       0, 0, 0}},
    '{ROW_REQ, nfba_pkg::CMD_FREE,  1023, 1'b1, '{nfba_pkg::ST_BAD_FREE, 0, 3, 0}},
    '{ROW_CFG, nfba_pkg::CMD_ALLOC, 1,    1'b0, '{nfba_pkg::ST_OK,       0, 0, 0}},
    '{ROW_REQ, nfba_pkg::CMD_ALLOC, 512,  1'b1, '{nfba_pkg::ST_FULL,     0, 3, 0}},
    '{ROW_REQ, nfba_pkg::CMD_FREE,  2,    1'b1, '{nfba_pkg::ST_BAD_FREE, 0, 3, 0}},
    '{ROW_REQ, nfba_pkg::CMD_FREE,  0,    1'b0, '{nfba_pkg::ST_OK,       0, 0, 0}},
    '{ROW_REQ, nfba_pkg::CMD_ALLOC, 0,    1'b0, '{nfba_pkg::ST_OK,       0, 0, 0}},
    '{ROW_CFG, nfba_pkg::CMD_ALLOC, 1024, 1'b0, '{nfba_pkg::ST_OK,       0, 0, 0}},
    '{ROW_REQ, nfba_pkg::CMD_FREE,  2,    1'b0, '{nfba_pkg::ST_OK,       0, 0, 0}}
  };

  // Random phases: extent count, items, share of allocates in percent
  int phase_plan [PHASES][3] = '{
    '{8, 120, 60}, '{1, 40, 50}, '{33, 150, 65}, '{0, 20, 50},
    '{2, 60, 50}, '{1024, 150, 70}, '{40, 100, 45}, '{2047, 80, 40},
    '{65, 150, 60}, '{3, 60, 55}, '{97, 120, 60}, '{1024, 75, 50}
  };

  function automatic int active_extents();
    return (extent_limit > nfba_pkg::MAX_EXTENTS) ? nfba_pkg::MAX_EXTENTS :
           int'(extent_limit);
  endfunction

  function automatic int first_free(int from, int lim);
    for (int i = from; i < lim; i++)
      if (!in_use[i]) return i;
    return lim;
  endfunction

  function automatic outcome_t resolve_request(nfba_pkg::cmd_t c,
                                               logic [nfba_pkg::ID_W-1:0] id);
    outcome_t o;
    int       lim;
    int       hit;
    lim       = active_extents();
    o.status  = nfba_pkg::ST_OK;
    o.granted = '0;
    if (c == nfba_pkg::CMD_ALLOC) begin
      hit = first_free(int'(search_pos), lim);
      // nothing from the search start up: wrap to extent zero
      if (hit == lim) hit = first_free(0, lim);
      if (hit == lim) begin
        o.status = nfba_pkg::ST_FULL;
      end else begin
        in_use[hit] = 1'b1;
        search_pos  = nfba_pkg::ID_W'(hit);
        used_total  = used_total + 1'b1;
        o.granted   = nfba_pkg::ID_W'(hit);
      end
    end else begin
      if (int'(id) >= lim || !in_use[id]) begin
        o.status = nfba_pkg::ST_BAD_FREE;
      end else begin
        in_use[id] = 1'b0;
        if (used_total != 0) used_total = used_total - 1'b1;
      end
    end
    o.count = used_total;
    o.empty = (used_total == 0);
    return o;
  endfunction

  // Mostly a used extent inside the active range, else any id
  function automatic logic [nfba_pkg::ID_W-1:0] pick_release_target();
    int lim;
    int start;
    int idx;
    lim = active_extents();
    if (lim != 0 && $urandom_range(0, 99) < 80) begin
      start = $urandom_range(0, lim - 1);
      for (int j = 0; j < lim; j++) begin
        idx = (start + j) % lim;
        if (in_use[idx]) return nfba_pkg::ID_W'(idx);
      end
    end
    return nfba_pkg::ID_W'($urandom_range(0, nfba_pkg::MAX_EXTENTS - 1));
  endfunction

  function automatic void log_fail(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  task automatic lower_req();
    if (req_up) begin
      req_ch.valid <= 1'b0;
      req_up = 1'b0;
    end
  endtask

  task automatic issue_request(input nfba_pkg::cmd_t c,
                               input logic [nfba_pkg::ID_W-1:0] id,
                               output outcome_t o);
    req_ch.valid     <= 1'b1;
    req_ch.cmd       <= c;
    req_ch.extent_id <= id;
    req_up = 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    o = resolve_request(c, id);
  endtask

  task automatic pace_sender();
    if ($urandom_range(0, 99) < src_idle_pct) begin
      lower_req();
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Write the extent count once every response is back
  task automatic set_extents(input logic [nfba_pkg::CNT_W-1:0] value);
    lower_req();
    while (outcome_q.size() != 0) @(posedge clk);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.num_extents <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    extent_limit = value;
  endtask

  initial begin : receiver
    int hold_left;
    int hold_done;
    hold_left    = 0;
    hold_done    = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_asks != hold_done) begin
        // long hold-off: let the block fill and stall its input
        rsp_ch.ready <= 1'b0;
        hold_left = STALL_CYCLES;
        hold_done++;
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : response_check
    outcome_t want;
    outcome_t got;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got.status  = rsp_ch.status;
      got.granted = rsp_ch.granted_id;
      got.count   = rsp_ch.used_count;
      got.empty   = rsp_ch.space_empty;
      if (outcome_q.size() == 0) begin
        log_fail($sformatf("unexpected response: status %0d id %0d count %0d empty %0d",
                           got.status, got.granted, got.count, got.empty));
      end else begin
        want = outcome_q.pop_front();
        if (got.status !== want.status || got.granted !== want.granted ||
            got.count !== want.count || got.empty !== want.empty)
          log_fail($sformatf({"mismatch: expected status %0d id %0d count %0d empty %0d,",
                              " got status %0d id %0d count %0d empty %0d"},
                             want.status, want.granted, want.count, want.empty,
                             got.status, got.granted, got.count, got.empty));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    int quiet;
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin : stimulus
    outcome_t                  o;
    int                        drawn;
    logic [nfba_pkg::ID_W-1:0] id;
    req_ch.valid       = 1'b0;
    req_ch.cmd         = nfba_pkg::CMD_ALLOC;
    req_ch.extent_id   = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.num_extents = '0;
    rst                = 1'b1;
    drawn              = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (opening_rows[r]) begin
      if (opening_rows[r].kind == ROW_CFG) begin
        set_extents(nfba_pkg::CNT_W'(opening_rows[r].arg));
      end else begin
        issue_request(opening_rows[r].cmd, nfba_pkg::ID_W'(opening_rows[r].arg), o);
        outcome_q.push_back(opening_rows[r].typed ? opening_rows[r].want : o);
        pace_sender();
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      set_extents(nfba_pkg::CNT_W'(phase_plan[p][0]));
      for (int k = 0; k < phase_plan[p][1]; k++) begin
        if (drawn == 375) begin
          src_idle_pct = 60;
          rcv_idle_pct = 11;
        end else if (drawn == 750) begin
          src_idle_pct = 0;
          rcv_idle_pct = 0;
        end
        if (drawn == 500) hold_asks++;
        if ($urandom_range(0, 99) < phase_plan[p][2]) begin
          id = nfba_pkg::ID_W'($urandom_range(0, nfba_pkg::MAX_EXTENTS - 1));
          issue_request(nfba_pkg::CMD_ALLOC, id, o);
        end else begin
          issue_request(nfba_pkg::CMD_FREE, pick_release_target(), o);
        end
        outcome_q.push_back(o);
        pace_sender();
        drawn++;
      end
    end

    lower_req();
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
